### design/ookfd_pkg.sv
// ----------------------------------------------------------------------------
// ookfd_pkg
// Shared types, register indexes and reset constants for the OOK remote
// frame decoder.
// ----------------------------------------------------------------------------
package ookfd_pkg;

    // default parameter values
    localparam int TICK_W_DEF = 16;
    localparam int CODE_W_DEF = 24;

    // fixed field widths
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int BIT_CNT_W  = 5;
    localparam int OUT_CODE_W = 24;
    localparam int ADDR_W     = 16;
    localparam int CMD_W      = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_LOW_MIN   = 3'd0,
        CFG_SYNC_LOW_MAX   = 3'd1,
        CFG_SHORT_HIGH_MIN = 3'd2,
        CFG_SHORT_HIGH_MAX = 3'd3,
        CFG_LONG_HIGH_MIN  = 3'd4,
        CFG_LONG_HIGH_MAX  = 3'd5,
        CFG_FRAME_BITS     = 3'd6
    } t_cfg_idx;

    // configuration reset values
    localparam logic [CFG_DATA_W-1:0] SYNC_LOW_MIN_RST   = 16'd145;
    localparam logic [CFG_DATA_W-1:0] SYNC_LOW_MAX_RST   = 16'd160;
    localparam logic [CFG_DATA_W-1:0] SHORT_HIGH_MIN_RST = 16'd4;
    localparam logic [CFG_DATA_W-1:0] SHORT_HIGH_MAX_RST = 16'd7;
    localparam logic [CFG_DATA_W-1:0] LONG_HIGH_MIN_RST  = 16'd14;
    localparam logic [CFG_DATA_W-1:0] LONG_HIGH_MAX_RST  = 16'd17;
    localparam logic [BIT_CNT_W-1:0]  FRAME_BITS_RST     = 5'd23;

    // request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_EDGE = 1'b1;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] sync_low_min;
        logic [CFG_DATA_W-1:0] sync_low_max;
        logic [CFG_DATA_W-1:0] short_high_min;
        logic [CFG_DATA_W-1:0] short_high_max;
        logic [CFG_DATA_W-1:0] long_high_min;
        logic [CFG_DATA_W-1:0] long_high_max;
        logic [BIT_CNT_W-1:0]  frame_bits;
    } t_cfg;

    typedef struct packed {
        logic req_type;
        logic line_level;
    } t_in_req;

    typedef struct packed {
        logic [OUT_CODE_W-1:0] code;
        logic [ADDR_W-1:0]     address;
        logic [CMD_W-1:0]      command;
    } t_out_res;

    typedef struct packed {
        logic     valid;
        t_out_res data;
    } t_res_bus;

endpackage

### design/ookfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// ookfd_cfg_regs
// Configuration register file: pulse windows and frame length.
// ----------------------------------------------------------------------------
module ookfd_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ookfd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ookfd_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output ookfd_pkg::t_cfg                   o_cfg
);
    import ookfd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SYNC_LOW_MIN:   n_cfg.sync_low_min   = i_cfg_data;
                CFG_SYNC_LOW_MAX:   n_cfg.sync_low_max   = i_cfg_data;
                CFG_SHORT_HIGH_MIN: n_cfg.short_high_min = i_cfg_data;
                CFG_SHORT_HIGH_MAX: n_cfg.short_high_max = i_cfg_data;
                CFG_LONG_HIGH_MIN:  n_cfg.long_high_min  = i_cfg_data;
                CFG_LONG_HIGH_MAX:  n_cfg.long_high_max  = i_cfg_data;
                CFG_FRAME_BITS:     n_cfg.frame_bits     = i_cfg_data[BIT_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_low_min   <= SYNC_LOW_MIN_RST;
            r_cfg.sync_low_max   <= SYNC_LOW_MAX_RST;
            r_cfg.short_high_min <= SHORT_HIGH_MIN_RST;
            r_cfg.short_high_max <= SHORT_HIGH_MAX_RST;
            r_cfg.long_high_min  <= LONG_HIGH_MIN_RST;
            r_cfg.long_high_max  <= LONG_HIGH_MAX_RST;
            r_cfg.frame_bits     <= FRAME_BITS_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### design/ookfd_core.sv
// ----------------------------------------------------------------------------
// ookfd_core
// Pulse timing counters, sync/bit classification, shift register and the
// two alternating frame slots.
// ----------------------------------------------------------------------------
module ookfd_core #(
    parameter int TICK_COUNT_WIDTH = ookfd_pkg::TICK_W_DEF,
    parameter int CODE_WIDTH       = ookfd_pkg::CODE_W_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  ookfd_pkg::t_in_req  i_req,
    input  ookfd_pkg::t_cfg     i_cfg,
    output ookfd_pkg::t_res_bus o_res
);
    import ookfd_pkg::*;

    localparam int CMP_W = (TICK_COUNT_WIDTH > CFG_DATA_W) ? TICK_COUNT_WIDTH : CFG_DATA_W;

    logic [TICK_COUNT_WIDTH-1:0] r_high, n_high;
    logic [TICK_COUNT_WIDTH-1:0] r_low, n_low;
    logic                        r_sync, n_sync;
    logic [CODE_WIDTH-1:0]       r_shift, n_shift;
    logic [BIT_CNT_W-1:0]        r_bits, n_bits;
    logic                        r_sel, n_sel;
    logic [CODE_WIDTH-1:0]       r_slot_a, n_slot_a;
    logic [CODE_WIDTH-1:0]       r_slot_b, n_slot_b;

    logic [CMP_W-1:0] w_h;
    logic [CMP_W-1:0] w_l;
    logic             w_sync_ok;
    logic             w_long_ok;
    logic             w_short_ok;
    logic             w_close;
    logic             w_res_valid;
    logic [31:0]      w_code_ext;

    assign w_h = CMP_W'(r_high);
    assign w_l = CMP_W'(r_low);

    assign w_short_ok = (w_h >= CMP_W'(i_cfg.short_high_min))
                     && (w_h <= CMP_W'(i_cfg.short_high_max));
    assign w_long_ok  = (w_h >= CMP_W'(i_cfg.long_high_min))
                     && (w_h <= CMP_W'(i_cfg.long_high_max));
    assign w_sync_ok  = (w_l >= CMP_W'(i_cfg.sync_low_min))
                     && (w_l <= CMP_W'(i_cfg.sync_low_max)) && w_short_ok;

    assign w_close = (r_bits >= i_cfg.frame_bits);

    always_comb begin
        n_high   = r_high;
        n_low    = r_low;
        n_sync   = r_sync;
        n_shift  = r_shift;
        n_bits   = r_bits;
        n_sel    = r_sel;
        n_slot_a = r_slot_a;
        n_slot_b = r_slot_b;
        w_res_valid = 1'b0;

        if (i_accept) begin
            if (i_req.req_type == REQ_TICK) begin
                if (i_req.line_level) begin
                    if (r_high != '1) n_high = r_high + TICK_COUNT_WIDTH'(1);
                end else begin
                    if (r_low != '1) n_low = r_low + TICK_COUNT_WIDTH'(1);
                end
                if (w_close) begin
                    n_bits  = '0;
                    n_sync  = 1'b0;
                    n_shift = '0;
                    n_sel   = ~r_sel;
                    if (r_sel) begin
                        n_slot_a = r_shift;
                    end else begin
                        n_slot_b = r_shift;
                    end
                    w_res_valid = (n_slot_a == n_slot_b);
                end
            end else begin
                n_high = '0;
                n_low  = '0;
                // sync takes priority over a data pulse
                priority if (w_sync_ok) begin
                    n_sync = 1'b1;
                end else if (r_sync && w_long_ok) begin
                    n_shift = {r_shift[CODE_WIDTH-2:0], 1'b1};
                    if (r_bits != '1) n_bits = r_bits + BIT_CNT_W'(1);
                end else if (r_sync && w_short_ok) begin
                    n_shift = {r_shift[CODE_WIDTH-2:0], 1'b0};
                    if (r_bits != '1) n_bits = r_bits + BIT_CNT_W'(1);
                end else begin
                    n_sync = r_sync;
                end
            end
        end
    end

    assign o_res.valid        = w_res_valid;
    assign w_code_ext         = 32'(n_slot_a);
    assign o_res.data.code    = w_code_ext[OUT_CODE_W-1:0];
    assign o_res.data.address = w_code_ext[OUT_CODE_W-1:CMD_W];
    assign o_res.data.command = w_code_ext[CMD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high   <= '0;
            r_low    <= '0;
            r_sync   <= 1'b0;
            r_shift  <= '0;
            r_bits   <= '0;
            r_sel    <= 1'b0;
            r_slot_a <= '0;
            r_slot_b <= '0;
        end else begin
            r_high   <= n_high;
            r_low    <= n_low;
            r_sync   <= n_sync;
            r_shift  <= n_shift;
            r_bits   <= n_bits;
            r_sel    <= n_sel;
            r_slot_a <= n_slot_a;
            r_slot_b <= n_slot_b;
        end
    end

    // a reported frame leaves both slots equal
    a_res_slots_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |=> (r_slot_a == r_slot_b))
        else $error("result reported with differing slots");

    // an edge clears both counters
    a_edge_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_req.req_type == REQ_EDGE) |=> (r_high == '0 && r_low == '0))
        else $error("edge did not clear tick counters");

    // closing a frame flips the slot select and drops sync
    a_close_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_req.req_type == REQ_TICK && w_close)
        |=> (r_sel != $past(r_sel) && !r_sync && r_bits == '0))
        else $error("frame close did not reset frame state");

endmodule

### design/ookfd_out_buf.sv
// ----------------------------------------------------------------------------
// ookfd_out_buf
// Result register with a skid stage so requests keep flowing while the
// downstream side stalls, until the skid stage is occupied.
// ----------------------------------------------------------------------------
module ookfd_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ookfd_pkg::t_res_bus i_res,
    output logic                o_full,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output ookfd_pkg::t_out_res o_out_data
);
    import ookfd_pkg::*;

    logic     r_out_valid, n_out_valid;
    t_out_res r_out_data, n_out_data;
    logic     r_skid_valid, n_skid_valid;
    t_out_res r_skid_data, n_skid_data;
    logic     w_take;

    assign w_take = r_out_valid && !i_out_stall;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        priority if (r_skid_valid) begin
            if (w_take) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (i_res.valid) begin
            if (!r_out_valid || w_take) begin
                n_out_valid = 1'b1;
                n_out_data  = i_res.data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = i_res.data;
            end
        end else if (w_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // skid entry only exists behind an occupied output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while output is empty");

    // no new result may arrive while the skid is occupied
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> !i_res.valid)
        else $error("result lost to a full output buffer");

    // a stalled result stays put
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result changed");

endmodule

### design/ook_remote_frame_decoder_top.sv
// A confirmed result is registered and shown on o_out_valid (via skid if the output is held).
// Throughput: one request per cycle while not stalled; each request updates all decode state.
// o_in_stall rises only when two results are held (output register plus skid) under i_out_stall.
// Reset (i_rst_n low, synchronous): counters, shift register, slots and select clear to zero,
// configuration registers return to their default windows and frame length.
// ----------------------------------------------------------------------------
// ook_remote_frame_decoder_top
// Pulse-width remote-control frame decoder with double-frame confirmation.
// ----------------------------------------------------------------------------
module ook_remote_frame_decoder_top #(
    parameter int TICK_COUNT_WIDTH = ookfd_pkg::TICK_W_DEF,
    parameter int CODE_WIDTH       = ookfd_pkg::CODE_W_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  ookfd_pkg::t_in_req               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output ookfd_pkg::t_out_res              o_out_data,
    input  logic                             i_cfg_we,
    input  logic [ookfd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ookfd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ookfd_pkg::*;

    t_cfg     w_cfg;
    t_res_bus w_res;
    logic     w_full;
    logic     w_accept;

    assign w_accept   = i_in_valid && !w_full;
    assign o_in_stall = w_full;

    ookfd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    ookfd_core #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH),
        .CODE_WIDTH       (CODE_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_req    (i_in_data),
        .i_cfg    (w_cfg),
        .o_res    (w_res)
    );

    ookfd_out_buf u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res       (w_res),
        .o_full      (w_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ook_remote_frame_decoder_top. Frames of sync and
// data pulses with random content are built from tick and edge requests.
// A scoreboard follows the decoder state and predicts each confirmed code,
// and random idling and stalling on both sides shake the handshakes.
// ----------------------------------------------------------------------------
module tb;
    import ookfd_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 1000;
    localparam int unsigned ITEMS_TARGET   = 1050;

    class remote_code_scoreboard;
        t_cfg                  cfg;
        logic [TICK_W_DEF-1:0] high_ticks;
        logic [TICK_W_DEF-1:0] low_ticks;
        logic                  sync_seen;
        logic                  slot_select;
        logic [CODE_W_DEF-1:0] shift_code;
        logic [CODE_W_DEF-1:0] slot_a;
        logic [CODE_W_DEF-1:0] slot_b;
        logic [BIT_CNT_W-1:0]  bit_count;
        t_out_res              confirmed_codes[$];
        int unsigned           mismatches;

        function new();
            cfg.sync_low_min   = SYNC_LOW_MIN_RST;
            cfg.sync_low_max   = SYNC_LOW_MAX_RST;
            cfg.short_high_min = SHORT_HIGH_MIN_RST;
            cfg.short_high_max = SHORT_HIGH_MAX_RST;
            cfg.long_high_min  = LONG_HIGH_MIN_RST;
            cfg.long_high_max  = LONG_HIGH_MAX_RST;
            cfg.frame_bits     = FRAME_BITS_RST;
            high_ticks  = '0;
            low_ticks   = '0;
            sync_seen   = 1'b0;
            slot_select = 1'b0;
            shift_code  = '0;
            slot_a      = '0;
            slot_b      = '0;
            bit_count   = '0;
            mismatches  = 0;
        endfunction

        function void take_cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                CFG_SYNC_LOW_MIN:   cfg.sync_low_min   = v;
                CFG_SYNC_LOW_MAX:   cfg.sync_low_max   = v;
                CFG_SHORT_HIGH_MIN: cfg.short_high_min = v;
                CFG_SHORT_HIGH_MAX: cfg.short_high_max = v;
                CFG_LONG_HIGH_MIN:  cfg.long_high_min  = v;
                CFG_LONG_HIGH_MAX:  cfg.long_high_max  = v;
                CFG_FRAME_BITS:     cfg.frame_bits     = v[BIT_CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function bit in_range(logic [TICK_W_DEF-1:0] v, logic [CFG_DATA_W-1:0] lo,
                              logic [CFG_DATA_W-1:0] hi);
            return (v >= lo) && (v <= hi);
        endfunction

        function void shift_in(logic b);
            shift_code = {shift_code[CODE_W_DEF-2:0], b};
            if (bit_count != '1) bit_count++;
        endfunction

        function int pending();
            return confirmed_codes.size();
        endfunction

        function void note_request(t_in_req r);
            logic [TICK_W_DEF-1:0] h;
            logic [TICK_W_DEF-1:0] l;
            t_out_res              res;
            if (r.req_type == REQ_TICK) begin
                if (r.line_level) begin
                    if (high_ticks != '1) high_ticks++;
                end else if (low_ticks != '1) begin
                    low_ticks++;
                end
                if (bit_count >= cfg.frame_bits) begin
                    bit_count = '0;
                    sync_seen = 1'b0;
                    if (slot_select) slot_a = shift_code;
                    else slot_b = shift_code;
                    shift_code  = '0;
                    slot_select = !slot_select;
                    // two frames in a row agree
                    if (slot_a == slot_b) begin
                        res.code    = slot_a;
                        res.address = slot_a[CMD_W +: ADDR_W];
                        res.command = slot_a[CMD_W-1:0];
                        confirmed_codes.push_back(res);
                    end
                end
            end else begin
                h = high_ticks;
                l = low_ticks;
                high_ticks = '0;
                low_ticks  = '0;
                // sync wins over a data pulse
                if (in_range(l, cfg.sync_low_min, cfg.sync_low_max) &&
                    in_range(h, cfg.short_high_min, cfg.short_high_max)) begin
                    sync_seen = 1'b1;
                end else if (sync_seen && in_range(h, cfg.long_high_min, cfg.long_high_max)) begin
                    shift_in(1'b1);
                end else if (sync_seen &&
                             in_range(h, cfg.short_high_min, cfg.short_high_max)) begin
                    shift_in(1'b0);
                end
            end
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_result(t_out_res got);
            t_out_res want;
            if (confirmed_codes.size() == 0) begin
                report($sformatf("code %06h with nothing pending", got.code));
            end else begin
                want = confirmed_codes.pop_front();
                if (got.code !== want.code)
                    report($sformatf("code %06h, want %06h", got.code, want.code));
                if (got.address !== want.address)
                    report($sformatf("address %04h, want %04h", got.address, want.address));
                if (got.command !== want.command)
                    report($sformatf("command %02h, want %02h", got.command, want.command));
            end
        endtask
    endclass

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_req               in_data  = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_res              out_data;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    remote_code_scoreboard sb = new();
    t_cfg        cur_cfg;
    int unsigned items_sent  = 0;
    int unsigned in_idle_pct = 38;
    int unsigned stall_pct   = 38;
    int unsigned hold_left   = 0;

    ook_remote_frame_decoder_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver: random stall, or a long hold-off when asked
    initial begin
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else begin
                out_stall = ($urandom_range(99, 0) < stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !in_stall) sb.note_request(in_data);
            if (out_valid && !out_stall) sb.check_result(out_data);
        end
    end

    initial begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int unsigned pick(int unsigned lo, int unsigned hi);
        return $urandom_range(hi, lo);
    endfunction

    task automatic send_req(input logic kind, input logic level);
        @(negedge clk);
        while ($urandom_range(99, 0) < in_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid           = 1'b1;
        in_data.req_type   = kind;
        in_data.line_level = level;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_pulse(input int unsigned hi, input int unsigned lo);
        repeat (hi) send_req(REQ_TICK, 1'b1);
        repeat (lo) send_req(REQ_TICK, 1'b0);
        send_req(REQ_EDGE, 1'($urandom_range(1, 0)));
    endtask

    // sync pulse, then data bits msb first
    task automatic send_frame(input logic [63:0] bits, input int unsigned nbits);
        int unsigned gap;
        send_pulse(pick(cur_cfg.short_high_min, cur_cfg.short_high_max),
                   pick(cur_cfg.sync_low_min, cur_cfg.sync_low_max));
        for (int i = int'(nbits) - 1; i >= 0; i--) begin
            gap = (cur_cfg.sync_low_min > 1) ? $urandom_range(1, 0) : 0;
            if (bits[i]) send_pulse(pick(cur_cfg.long_high_min, cur_cfg.long_high_max), gap);
            else send_pulse(pick(cur_cfg.short_high_min, cur_cfg.short_high_max), gap);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] v);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we   = 1'b0;
        sb.take_cfg_write(idx, v);
    endtask

    task automatic reconfigure(input logic [15:0] sl_lo, input logic [15:0] sl_hi,
                               input logic [15:0] sh_lo, input logic [15:0] sh_hi,
                               input logic [15:0] lg_lo, input logic [15:0] lg_hi,
                               input logic [BIT_CNT_W-1:0] fb);
        drain();
        // a tick that closes an unmatched frame leaves no result to wait for
        repeat (4) @(negedge clk);
        cfg_write(CFG_SYNC_LOW_MIN, sl_lo);
        cfg_write(CFG_SYNC_LOW_MAX, sl_hi);
        cfg_write(CFG_SHORT_HIGH_MIN, sh_lo);
        cfg_write(CFG_SHORT_HIGH_MAX, sh_hi);
        cfg_write(CFG_LONG_HIGH_MIN, lg_lo);
        cfg_write(CFG_LONG_HIGH_MAX, lg_hi);
        cfg_write(CFG_FRAME_BITS, CFG_DATA_W'(fb));
        cur_cfg.sync_low_min   = sl_lo;
        cur_cfg.sync_low_max   = sl_hi;
        cur_cfg.short_high_min = sh_lo;
        cur_cfg.short_high_max = sh_hi;
        cur_cfg.long_high_min  = lg_lo;
        cur_cfg.long_high_max  = lg_hi;
        cur_cfg.frame_bits     = fb;
    endtask

    initial begin
        logic [63:0]   bits;
        logic [15:0]   sl;
        logic [15:0]   sh;
        logic [15:0]   sh_top;
        logic [15:0]   lg;
        int unsigned   fb;
        int unsigned   sel;
        int unsigned   phase_no;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // short frames: a data pulse before any sync, then one code sent twice
        reconfigure(16'd2, 16'd3, 16'd1, 16'd1, 16'd2, 16'd2, 5'd2);
        send_pulse(2, 0);
        send_frame(64'b10, 2);
        send_frame(64'b10, 2);
        send_req(REQ_TICK, 1'b0);

        // bit count saturates at 31 with zero-tick pulses, then a full-width code
        reconfigure(16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 5'd31);
        bits = {$urandom, $urandom};
        send_frame(bits, 40);
        send_frame(bits, 40);
        reconfigure(16'd1, 16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 5'd24);
        bits = {$urandom, $urandom};
        send_frame(bits, 24);
        send_frame(bits, 24);
        send_req(REQ_TICK, 1'b0);

        reconfigure(16'd2, 16'd3, 16'd1, 16'd1, 16'd2, 16'd2, 5'd1);
        send_frame(64'd1, 1);
        send_req(REQ_TICK, 1'b0);

        // every edge is a sync and every tick after the first confirms an empty code;
        // the receiver holds off so the decoder fills up
        reconfigure(16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 5'd0);
        in_idle_pct = 0;
        hold_left   = 60;
        repeat (40) send_req(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));

        phase_no = 0;
        while (items_sent < ITEMS_TARGET) begin
            sl     = 16'($urandom_range(6, 2));
            sh     = 16'($urandom_range(2, 0));
            sh_top = 16'(sh + $urandom_range(2, 0));
            lg     = ($urandom_range(4, 0) == 0) ? sh
                                                 : 16'(sh_top + 1 + $urandom_range(2, 0));
            sel    = $urandom_range(9, 0);
            fb     = (sel == 0) ? 0 : (sel == 9) ? $urandom_range(31, 24) : $urandom_range(6, 1);
            reconfigure(sl, 16'(sl + $urandom_range(3, 0)), sh, sh_top, lg,
                        16'(lg + $urandom_range(3, 0)), BIT_CNT_W'(fb));
            in_idle_pct = (phase_no == 0) ? 0 : 38;
            stall_pct   = (phase_no == 0) ? 0 : 38;
            repeat ($urandom_range(8, 3)) begin
                if (items_sent >= ITEMS_TARGET) break;
                sel  = $urandom_range(99, 0);
                bits = {$urandom, $urandom};
                if (sel < 70) begin
                    send_frame(bits, fb);
                    send_frame(bits, fb);
                end else if (sel < 80) begin
                    send_frame(bits, $urandom_range(fb + 2, 0));
                end else if (sel < 88) begin
                    // data pulses with no sync ahead of them
                    repeat ($urandom_range(4, 1))
                        send_pulse(pick(cur_cfg.long_high_min, cur_cfg.long_high_max), 0);
                end else begin
                    repeat ($urandom_range(15, 3))
                        send_req(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
                end
            end
            send_req(REQ_TICK, 1'($urandom_range(1, 0)));
            phase_no++;
        end

        drain();
        repeat (10) @(negedge clk);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
